>>> rtl/weekly_alarm_next_run_macros.svh
// Assertion macros shared by the weekly alarm RTL.
// Expects clk and rst in scope at the point of use.
`ifndef WEEKLY_ALARM_NEXT_RUN_MACROS_SVH
`define WEEKLY_ALARM_NEXT_RUN_MACROS_SVH

// same-cycle implication, masked during reset
`define WANR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define WANR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wanr_pkg.sv
// Types, constants and helper functions for the weekly alarm block.
// No dependencies; imported by every module of the block.
package wanr_pkg;

  localparam logic [19:0] SECS_PER_DAY  = 20'd86400;
  localparam logic [19:0] LEAD_SECS     = 20'd60;
  localparam logic [6:0]  WEEKDAY_MASK  = 7'h3E;
  localparam logic [6:0]  ALL_DAYS_MASK = 7'h7F;
  localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;
  localparam logic [3:0]  EPOCH_WEEKDAY = 4'd4;
  // one week, keeps local time positive for any offset
  localparam logic [32:0] WEEK_BIAS     = 33'd604800;
  // 86400 = 128 * 675; x / 675 = (x * DAY_RECIP) >> RECIP_SHIFT for x < 2^26
  localparam logic [9:0]  DAY_ODD       = 10'd675;
  localparam logic [26:0] DAY_RECIP     = 27'd101806633;
  localparam int unsigned RECIP_SHIFT   = 36;

  typedef enum logic [1:0] {
    MODE_DAILY    = 2'd0,
    MODE_WEEKDAYS = 2'd1,
    MODE_WEEKLY   = 2'd2
  } freq_mode_t;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_FREQ_MODE    = 3'd1,
    REG_DAY_MASK     = 3'd2,
    REG_ALARM_HOUR   = 3'd3,
    REG_ALARM_MINUTE = 3'd4,
    REG_ZONE_OFFSET  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               enable;
    logic [1:0]         frequency_mode;
    logic [6:0]         day_mask;
    logic [4:0]         alarm_hour;
    logic [5:0]         alarm_minute;
    logic signed [10:0] zone_offset_min;
  } wanr_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        disabled;
    logic [2:0]  day_sel;   // days after today, 7 = next week
    logic [32:0] base;      // now - seconds since local midnight + alarm time
  } wanr_job_t;

  function automatic logic [2:0] mod7_16(input logic [15:0] d);
    logic [5:0] s;
    logic [3:0] t;
    // 8 == 1 mod 7: sum octal digits
    s = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9]) + 6'(d[14:12]) + 6'(d[15]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    if (t >= DAYS_PER_WEEK) t = t - DAYS_PER_WEEK;
    if (t >= DAYS_PER_WEEK) t = t - DAYS_PER_WEEK;
    return t[2:0];
  endfunction

  function automatic logic [19:0] day_offset(input logic [2:0] k);
    logic [19:0] r;
    case (k)
      3'd0:    r = 20'd0;
      3'd1:    r = 20'd86400;
      3'd2:    r = 20'd172800;
      3'd3:    r = 20'd259200;
      3'd4:    r = 20'd345600;
      3'd5:    r = 20'd432000;
      3'd6:    r = 20'd518400;
      default: r = 20'd604800;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/wanr_front.sv
// Front end: accepts time beats, finds local day, weekday and time of day,
// and picks the alarm day. Depends on wanr_pkg and the assertion macros.
`include "weekly_alarm_next_run_macros.svh"

module wanr_front #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        now_seconds,
  input  wanr_pkg::wanr_cfg_t cfg,
  input  logic               job_pop,
  output logic               job_push,
  output wanr_pkg::wanr_job_t job
);
  import wanr_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // beats in the pipe plus beats in the queue
  logic [CW-1:0] credits;
  logic [CW-1:0] credits_next;
  logic          accept;

  assign in_stall = (credits >= CW'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign credits_next = credits + CW'(accept) - CW'(job_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  // stage 1: biased local time
  logic signed [17:0] off_sec;
  logic [32:0]        biased_c;
  logic               v1;
  logic [31:0]        now1;
  logic [32:0]        biased1;

  assign off_sec  = (18'(cfg.zone_offset_min) <<< 6) - (18'(cfg.zone_offset_min) <<< 2);
  assign biased_c = {1'b0, now_seconds} + 33'(off_sec) + WEEK_BIAS;

  // stage 2: reciprocal product
  logic        v2;
  logic [31:0] now2;
  logic [25:0] q1_2;
  logic [6:0]  low2;
  logic [52:0] prod2;

  // stage 3: day and high remainder
  logic [15:0] qd;
  logic [25:0] back_c;
  logic [25:0] diff_c;
  logic [15:0] day_c;
  logic [9:0]  rhi_c;
  logic        v3;
  logic [31:0] now3;
  logic [15:0] day3;
  logic [9:0]  rhi3;
  logic [6:0]  low3;

  assign qd     = prod2[RECIP_SHIFT+15:RECIP_SHIFT];
  assign back_c = 26'(qd) * 26'(DAY_ODD);
  assign diff_c = q1_2 - back_c;

  always_comb begin
    if (diff_c >= 26'(DAY_ODD)) begin
      day_c = qd + 16'd1;
      rhi_c = 10'(diff_c - 26'(DAY_ODD));
    end else begin
      day_c = qd;
      rhi_c = diff_c[9:0];
    end
  end

  // stage 4: time of day, weekday, base
  logic [16:0] rem_c;
  logic [3:0]  wd_sum;
  logic [2:0]  wd_c;
  logic [10:0] hm_c;
  logic [16:0] target_c;
  logic [32:0] base_c;
  logic        v4;
  logic [16:0] rem4;
  logic [2:0]  wd4;
  logic [16:0] target4;
  logic [32:0] base4;

  assign rem_c    = {rhi3, low3};
  assign wd_sum   = 4'(mod7_16(day3)) + EPOCH_WEEKDAY;
  assign wd_c     = (wd_sum >= DAYS_PER_WEEK) ? 3'(wd_sum - DAYS_PER_WEEK) : wd_sum[2:0];
  assign hm_c     = ({cfg.alarm_hour, 6'b0} - {4'b0, cfg.alarm_hour, 2'b0})
                    + 11'(cfg.alarm_minute);
  assign target_c = ({hm_c, 6'b0} - {4'b0, hm_c, 2'b0});
  assign base_c   = {1'b0, now3} - 33'(rem_c) + 33'(target_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    now1    <= now_seconds;
    biased1 <= biased_c;
    now2    <= now1;
    q1_2    <= biased1[32:7];
    low2    <= biased1[6:0];
    prod2   <= 53'(biased1[32:7]) * 53'(DAY_RECIP);
    now3    <= now2;
    day3    <= day_c;
    rhi3    <= rhi_c;
    low3    <= low2;
    rem4    <= rem_c;
    wd4     <= wd_c;
    target4 <= target_c;
    base4   <= base_c;
  end

  // stage 5: allowed days and first qualifying day
  logic [6:0] eff_mask;
  logic [6:0] hit;
  logic [2:0] sel;
  logic [3:0] wk;
  logic [19:0] limit;

  always_comb begin
    case (cfg.frequency_mode)
      MODE_WEEKDAYS: eff_mask = WEEKDAY_MASK;
      MODE_WEEKLY:   eff_mask = (cfg.day_mask == 7'd0) ? ALL_DAYS_MASK : cfg.day_mask;
      default:       eff_mask = ALL_DAYS_MASK;
    endcase
  end

  assign limit = 20'(rem4) + LEAD_SECS;

  always_comb begin
    hit = '0;
    wk  = '0;
    for (int k = 0; k < 7; k++) begin
      wk = 4'(wd4) + 4'(k);
      if (wk >= DAYS_PER_WEEK) wk = wk - DAYS_PER_WEEK;
      hit[k] = eff_mask[wk[2:0]] && ((day_offset(3'(k)) + 20'(target4)) > limit);
    end
  end

  always_comb begin
    sel = 3'd7;
    for (int k = 6; k >= 0; k--) begin
      if (hit[k]) sel = 3'(k);
    end
  end

  assign job_push     = v4;
  assign job.disabled = !cfg.enable;
  assign job.day_sel  = sel;
  assign job.base     = base4;

  `WANR_ASSERT_IMPLY(a_rem_in_day, v4, rem4 < 17'(SECS_PER_DAY), "time of day out of range")
  `WANR_ASSERT_IMPLY(a_credit_bound, 1'b1, credits <= CW'(QUEUE_DEPTH), "credit overflow")

endmodule

>>> rtl/wanr_queue.sv
// Short job queue between front and back ends.
// Depends on wanr_pkg and the assertion macros.
`include "weekly_alarm_next_run_macros.svh"

module wanr_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wanr_pkg::wanr_job_t wdata,
  input  logic                pop,
  output logic                nonempty,
  output wanr_pkg::wanr_job_t rdata
);
  import wanr_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  wanr_job_t     mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          full;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  `WANR_ASSERT_IMPLY(a_no_overflow, push, !full, "push into full queue")
  `WANR_ASSERT_IMPLY(a_no_underflow, pop, nonempty, "pop from empty queue")

endmodule

>>> rtl/wanr_back.sv
// Back end: adds the chosen day to the base (zero when disabled) and holds the result beat.
// Depends on wanr_pkg and the assertion macros.
`include "weekly_alarm_next_run_macros.svh"

module wanr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  wanr_pkg::wanr_job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [32:0]         next_run_seconds
);
  import wanr_pkg::*;

  logic [32:0] result_c;

  assign job_pop  = job_valid && (!out_valid || !out_stall);
  assign result_c = job.disabled ? '0 : job.base + 33'(day_offset(job.day_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      next_run_seconds <= result_c;
    end
  end

  `WANR_ASSERT_NEXT(a_enabled_nonzero, job_pop && !job.disabled, next_run_seconds != '0,
                    "enabled alarm gave zero")

endmodule

>>> rtl/weekly_alarm_next_run.sv
// Weekly alarm next-run calculator: one result beat for every time beat, one beat per
// cycle while neither in_stall nor out_stall holds the flow. Four front stages (local
// time, reciprocal divide by one day, remainder fix-up, weekday and base) feed a
// QUEUE_DEPTH-entry queue; the back end adds the chosen day and registers the result.
// The input stalls once QUEUE_DEPTH beats are in the front stages and queue together,
// so full rate needs QUEUE_DEPTH of at least six. Registers are written through
// cfg_write/cfg_index/cfg_data and must only change while no beat is in flight.
// Depends on wanr_pkg, wanr_front, wanr_queue and wanr_back.

module weekly_alarm_next_run #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [32:0] next_run_seconds
);
  import wanr_pkg::*;

  wanr_cfg_t cfg;
  logic      job_push;
  logic      job_pop;
  logic      job_valid;
  wanr_job_t job_in;
  wanr_job_t job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.frequency_mode  <= MODE_DAILY;
      cfg.day_mask        <= ALL_DAYS_MASK;
      cfg.alarm_hour      <= 5'd6;
      cfg.alarm_minute    <= 6'd0;
      cfg.zone_offset_min <= 11'sd0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:       cfg.enable          <= cfg_data[0];
        REG_FREQ_MODE:    cfg.frequency_mode  <= cfg_data[1:0];
        REG_DAY_MASK:     cfg.day_mask        <= cfg_data[6:0];
        REG_ALARM_HOUR:   cfg.alarm_hour      <= cfg_data[4:0];
        REG_ALARM_MINUTE: cfg.alarm_minute    <= cfg_data[5:0];
        REG_ZONE_OFFSET:  cfg.zone_offset_min <= cfg_data;
        default: ;
      endcase
    end
  end

  wanr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .now_seconds(now_seconds),
    .cfg        (cfg),
    .job_pop    (job_pop),
    .job_push   (job_push),
    .job        (job_in)
  );

  wanr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wdata   (job_in),
    .pop     (job_pop),
    .nonempty(job_valid),
    .rdata   (job_out)
  );

  wanr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_valid),
    .job             (job_out),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .next_run_seconds(next_run_seconds)
  );

endmodule
